// ===== rtl/igpa_pkg.sv =====
// igpa_pkg: constants, widths and state codes for the information-gain block.
// Used by the histogram, log, divider and top-level modules. No dependencies.
package igpa_pkg;
   localparam int NUM_ATTRS = 4;
   localparam int NUM_VALUES = 4;
   localparam int MAX_ROWS = 1024;
   localparam int IN_ATTR_FIELDS = 4;
   localparam int USED_ATTRS = (NUM_ATTRS < IN_ATTR_FIELDS) ? NUM_ATTRS : IN_ATTR_FIELDS;
   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam int HIST_DEPTH = NUM_ATTRS * NUM_VALUES * 2;
   localparam int HADDR_W = $clog2(HIST_DEPTH);
   localparam int VAL_W = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
   localparam int ATTR_W = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
   localparam int LG_W = 5 + 16;
   localparam int T_W = CNT_W + LG_W;
   localparam int ACC_W = T_W + 4 + ATTR_W;
   localparam int GAIN_W = 17;
   localparam int GAIN_MAX = 65536;
   localparam int QUO_W = ACC_W;

   // top-level sequencer codes
   localparam logic [3:0] ST_LOAD  = 4'd0;
   localparam logic [3:0] ST_TOT   = 4'd1;
   localparam logic [3:0] ST_TWAIT = 4'd2;
   localparam logic [3:0] ST_RDQ   = 4'd3;
   localparam logic [3:0] ST_RDP   = 4'd4;
   localparam logic [3:0] ST_VAL   = 4'd5;
   localparam logic [3:0] ST_VWAIT = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_DWAIT = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;
   localparam logic [3:0] ST_CLR   = 4'd10;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
   } tlog_req_type;
endpackage

// ===== rtl/igpa_tlog.sv =====
// igpa_tlog: iterative T(c) = c*log2(c) in Q.16, one fraction bit per squaring.
// Shares one 31x31 squarer across the 16 fraction steps. Uses igpa_pkg.
module igpa_tlog (
   input  logic                         clock,
   input  logic                         reset,
   input  igpa_pkg::tlog_req_type       req,
   output logic                         done,
   output logic [igpa_pkg::T_W-1:0]     tval
);
   localparam logic [4:0] LAST_STEP = 5'd17;
   logic [30:0] x_ff, x_in;
   logic [15:0] frac_ff, frac_in;
   logic [4:0]  k_ff, k_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [igpa_pkg::CNT_W-1:0] c_ff, c_in;
   logic [igpa_pkg::T_W-1:0]   t_ff, t_in;
   logic [61:0] sq_ff, sq_in;
   logic [31:0] sh;
   logic [4:0]  k_det;
   logic        phase_ff, phase_in;

   always_comb begin
      k_det = 5'd0;
      for (int i = 0; i < igpa_pkg::CNT_W; i++) begin
         if (req.count[i]) k_det = 5'(i);
      end
   end

   assign sh = 32'(sq_ff >> 30);

   always_comb begin
      x_in = x_ff; frac_in = frac_ff; k_in = k_ff; step_in = step_ff;
      busy_in = busy_ff; done_in = 1'b0; c_in = c_ff; t_in = t_ff;
      sq_in = sq_ff; phase_in = phase_ff;
      if (req.start) begin
         busy_in = 1'b1; c_in = req.count; k_in = k_det; frac_in = 16'd0;
         step_in = 5'd0; phase_in = 1'b0;
         x_in = 31'(32'(req.count) << (5'd30 - k_det));
      end else if (busy_ff) begin
         if (c_ff == '0) begin
            t_in = '0; busy_in = 1'b0; done_in = 1'b1;
         end else if (step_ff == 5'd16) begin
            sq_in = 62'(c_ff) * 62'({k_ff, frac_ff});
            step_in = LAST_STEP;
         end else if (step_ff == LAST_STEP) begin
            t_in = igpa_pkg::T_W'(sq_ff); busy_in = 1'b0; done_in = 1'b1;
         end else if (!phase_ff) begin
            sq_in = 62'(x_ff) * 62'(x_ff);
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            step_in = step_ff + 5'd1;
            if (sh[31]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               x_in = sh[31:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               x_in = sh[30:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      x_ff <= x_in; frac_ff <= frac_in; k_ff <= k_in; step_ff <= step_in;
      c_ff <= c_in; t_ff <= t_in; sq_ff <= sq_in; phase_ff <= phase_in;
   end

   assign done = done_ff;
   assign tval = t_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("tlog done while busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> step_ff <= LAST_STEP)
      else $error("tlog step overrun");
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("tlog done held");
endmodule

// ===== rtl/igpa_div.sv =====
// igpa_div: restoring divider, one quotient bit per cycle.
// Divides the gain numerator by the row count. Uses igpa_pkg.
module igpa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [igpa_pkg::ACC_W-1:0]    dividend,
   input  logic [igpa_pkg::CNT_W-1:0]    divisor,
   output logic                          done,
   output logic [igpa_pkg::QUO_W-1:0]    quotient
);
   localparam int CW = $clog2(igpa_pkg::ACC_W + 1);
   logic [igpa_pkg::ACC_W-1:0] q_ff, q_in;
   logic [igpa_pkg::CNT_W:0]   r_ff, r_in;
   logic [igpa_pkg::CNT_W-1:0] d_ff, d_in;
   logic [CW-1:0]              n_ff, n_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [igpa_pkg::CNT_W:0]   trial;

   assign trial = {r_ff[igpa_pkg::CNT_W-1:0], q_ff[igpa_pkg::ACC_W-1]};

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         n_in = CW'(igpa_pkg::ACC_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[igpa_pkg::ACC_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[igpa_pkg::ACC_W-2:0], 1'b0};
         end
         n_in = n_ff - CW'(1);
         if (n_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;

   // zero divisor (empty set) runs through but its quotient is discarded
   assert property (@(posedge clock) disable iff (reset)
                    (busy_ff && d_ff != '0) |-> r_ff < {1'b0, d_ff})
      else $error("div remainder too large");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("div done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("div done held");
endmodule

// ===== rtl/information_gain_per_attribute.sv =====
// information_gain_per_attribute: ID3 gain per attribute over a loaded row set.
// Instantiates igpa_tlog and igpa_div; uses igpa_pkg.
//
//  channel | direction | ports
//  req     | in        | req_valid/req_stall, attr0..3_value, label, last_row
//  rsp     | out       | rsp_valid/rsp_stall, attribute_index, gain, last_result
//
// Rows load one per cycle while loading (histogram read-modify-write in flops, all attrs
// at once). A last_row word starts evaluation: per attribute (3+3V) T(c) evaluations in
// the shared log unit, then a divide; the log unit sets the pace. Then the histogram is
// cleared one bin at a time before req is free again.
// Reset is synchronous, clears counts and control. req_stall is high whenever not loading.
module information_gain_per_attribute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_attr0_value,
   input  logic [1:0]  req_attr1_value,
   input  logic [1:0]  req_attr2_value,
   input  logic [1:0]  req_attr3_value,
   input  logic        req_label,
   input  logic        req_last_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_attribute_index,
   output logic [16:0] rsp_gain,
   output logic        rsp_last_result
);
   localparam int CW = igpa_pkg::CNT_W;
   localparam int AW = igpa_pkg::ATTR_W;
   localparam int VW = igpa_pkg::VAL_W;
   localparam int HW = igpa_pkg::HADDR_W;
   localparam int ACW = igpa_pkg::ACC_W;

   // histogram in flops: each row bumps one bin per attribute
   logic [CW-1:0] hist_ff [igpa_pkg::HIST_DEPTH];
   logic [CW-1:0] rows_ff, pos_ff;
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] attr_ff, attr_in;
   logic [VW-1:0] val_ff, val_in;
   logic [1:0]    term_ff, term_in;       // which T() inside a group
   logic [ACW-1:0] acc_ff, acc_in;
   logic [HW-1:0] clr_ff, clr_in;
   logic [CW-1:0] qv_ff, qv_in, pv_ff, pv_in;
   logic          rsp_valid_ff;
   logic [1:0]    idx_ff;
   logic [16:0]   gain_ff;
   logic          last_ff;
   logic          row_take, count_ok;
   logic [1:0]    raw_val [4];
   logic [VW-1:0] vsel [4];
   igpa_pkg::tlog_req_type treq;
   logic                   tdone;
   logic [igpa_pkg::T_W-1:0] tval;
   logic          dstart, ddone;
   logic [igpa_pkg::QUO_W-1:0] quo;
   logic [CW-1:0] tcount;
   logic [HW-1:0] base_addr;
   logic          out_load;

   assign raw_val[0] = req_attr0_value;
   assign raw_val[1] = req_attr1_value;
   assign raw_val[2] = req_attr2_value;
   assign raw_val[3] = req_attr3_value;
   always_comb begin
      for (int a = 0; a < 4; a++) begin
         if (32'(raw_val[a]) >= igpa_pkg::NUM_VALUES) vsel[a] = VW'(igpa_pkg::NUM_VALUES - 1);
         else vsel[a] = VW'(raw_val[a]);
      end
   end

   assign req_stall = (state_ff != igpa_pkg::ST_LOAD);
   assign row_take = req_valid && !req_stall;
   assign count_ok = (32'(rows_ff) < igpa_pkg::MAX_ROWS);

   always_ff @(posedge clock) begin
      for (int h = 0; h < igpa_pkg::HIST_DEPTH; h++) begin
         if (reset) begin
            hist_ff[h] <= '0;
         end else if (state_ff == igpa_pkg::ST_CLR) begin
            if (clr_ff == HW'(h)) hist_ff[h] <= '0;
         end else if (row_take && count_ok) begin
            for (int a = 0; a < igpa_pkg::USED_ATTRS; a++) begin
               if (h == (a * igpa_pkg::NUM_VALUES + int'(vsel[a])) * 2 + int'(req_label))
                  hist_ff[h] <= hist_ff[h] + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0; pos_ff <= '0;
      end else if (state_ff == igpa_pkg::ST_CLR && clr_ff == HW'(igpa_pkg::HIST_DEPTH - 1)) begin
         rows_ff <= '0; pos_ff <= '0;
      end else if (row_take && count_ok) begin
         rows_ff <= rows_ff + CW'(1);
         pos_ff <= pos_ff + CW'(req_label);
      end
   end

   assign base_addr = HW'((int'(attr_ff) * igpa_pkg::NUM_VALUES + int'(val_ff)) * 2);

   // which count goes to the log unit for this term
   always_comb begin
      unique case (term_ff)
         2'd0: tcount = (state_ff == igpa_pkg::ST_TOT || state_ff == igpa_pkg::ST_TWAIT)
                        ? rows_ff : CW'(pv_ff + qv_ff);
         2'd1: tcount = (state_ff == igpa_pkg::ST_TOT || state_ff == igpa_pkg::ST_TWAIT)
                        ? pos_ff : pv_ff;
         2'd2: tcount = (state_ff == igpa_pkg::ST_TOT || state_ff == igpa_pkg::ST_TWAIT)
                        ? CW'(rows_ff - pos_ff) : qv_ff;
         default: tcount = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff; attr_in = attr_ff; val_in = val_ff; term_in = term_ff;
      acc_in = acc_ff; clr_in = clr_ff; qv_in = qv_ff; pv_in = pv_ff;
      treq.start = 1'b0; treq.count = tcount; dstart = 1'b0; out_load = 1'b0;
      unique case (state_ff)
         igpa_pkg::ST_LOAD: begin
            if (row_take && req_last_row) begin
               state_in = igpa_pkg::ST_TOT; attr_in = '0; term_in = 2'd0; acc_in = '0;
            end
         end
         igpa_pkg::ST_TOT: begin
            treq.start = 1'b1; state_in = igpa_pkg::ST_TWAIT;
         end
         igpa_pkg::ST_TWAIT: begin
            if (tdone) begin
               acc_in = (term_ff == 2'd0) ? acc_ff + ACW'(tval) : acc_ff - ACW'(tval);
               if (term_ff == 2'd2) begin
                  state_in = igpa_pkg::ST_RDQ; val_in = '0; term_in = 2'd0;
               end else begin
                  term_in = term_ff + 2'd1; state_in = igpa_pkg::ST_TOT;
               end
            end
         end
         igpa_pkg::ST_RDQ: begin
            qv_in = hist_ff[base_addr]; state_in = igpa_pkg::ST_RDP;
         end
         igpa_pkg::ST_RDP: begin
            pv_in = hist_ff[HW'(base_addr + HW'(1))]; state_in = igpa_pkg::ST_VAL;
         end
         igpa_pkg::ST_VAL: begin
            treq.start = 1'b1; state_in = igpa_pkg::ST_VWAIT;
         end
         igpa_pkg::ST_VWAIT: begin
            if (tdone) begin
               acc_in = (term_ff == 2'd0) ? acc_ff - ACW'(tval) : acc_ff + ACW'(tval);
               if (term_ff != 2'd2) begin
                  term_in = term_ff + 2'd1; state_in = igpa_pkg::ST_VAL;
               end else if (32'(val_ff) == igpa_pkg::NUM_VALUES - 1) begin
                  term_in = 2'd0; state_in = igpa_pkg::ST_DIV;
               end else begin
                  term_in = 2'd0; val_in = val_ff + VW'(1); state_in = igpa_pkg::ST_RDQ;
               end
            end
         end
         igpa_pkg::ST_DIV: begin
            dstart = 1'b1; state_in = igpa_pkg::ST_DWAIT;
         end
         igpa_pkg::ST_DWAIT: begin
            if (ddone) begin
               out_load = 1'b1; state_in = igpa_pkg::ST_OUT;
            end
         end
         igpa_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               if (32'(attr_ff) == igpa_pkg::USED_ATTRS - 1) begin
                  state_in = igpa_pkg::ST_CLR; clr_in = '0;
               end else begin
                  attr_in = attr_ff + AW'(1); term_in = 2'd0; acc_in = '0;
                  state_in = igpa_pkg::ST_TOT;
               end
            end
         end
         igpa_pkg::ST_CLR: begin
            clr_in = clr_ff + HW'(1);
            if (clr_ff == HW'(igpa_pkg::HIST_DEPTH - 1)) state_in = igpa_pkg::ST_LOAD;
         end
         default: state_in = igpa_pkg::ST_LOAD;
      endcase
   end

   igpa_tlog u_tlog (.clock(clock), .reset(reset), .req(treq), .done(tdone), .tval(tval));

   igpa_div u_div (.clock(clock), .reset(reset), .start(dstart), .dividend(acc_ff),
                   .divisor(rows_ff), .done(ddone), .quotient(quo));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= igpa_pkg::ST_LOAD; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      attr_ff <= attr_in; val_ff <= val_in; term_ff <= term_in; acc_ff <= acc_in;
      clr_ff <= clr_in; qv_ff <= qv_in; pv_ff <= pv_in;
      if (out_load) begin
         idx_ff <= 2'(attr_ff);
         last_ff <= (32'(attr_ff) == igpa_pkg::USED_ATTRS - 1);
         // nonpositive numerator or empty set gives zero
         if (rows_ff == '0 || acc_ff[ACW-1] || acc_ff == '0) gain_ff <= '0;
         else if (quo > igpa_pkg::QUO_W'(igpa_pkg::GAIN_MAX)) gain_ff <= 17'(igpa_pkg::GAIN_MAX);
         else gain_ff <= 17'(quo);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_attribute_index = idx_ff;
   assign rsp_gain = gain_ff;
   assign rsp_last_result = last_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> state_ff == igpa_pkg::ST_OUT)
      else $error("result outside output state");
   assert property (@(posedge clock) disable iff (reset) rows_ff >= pos_ff)
      else $error("positive count exceeds rows");
   assert property (@(posedge clock) disable iff (reset) 32'(rows_ff) <= igpa_pkg::MAX_ROWS)
      else $error("row count overflow");
endmodule
